@@ design/assert_macros.svh @@
// Assertion macros used by the design files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/sdspi_pkg.sv @@
// Package for the SD card SPI-mode host: request codes, status codes, command
// numbers, frame constants and the command frame byte function. No dependencies.
package sdspi_pkg;

   localparam int unsigned BLOCK_BYTES     = 512;
   localparam int unsigned MAX_POLLS_DEF   = 8;
   localparam int unsigned CNT_W           = 10;
   localparam int unsigned IDX_W           = 9;

   localparam logic [1:0] REQ_INIT = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_BYTE = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_REPLY   = 3'd1;
   localparam logic [2:0] ST_IDLE_ERR   = 3'd2;
   localparam logic [2:0] ST_READY_FAIL = 3'd3;
   localparam logic [2:0] ST_READ_ERR   = 3'd4;

   localparam logic [5:0] CMD_GO_IDLE = 6'd0;
   localparam logic [5:0] CMD_SEND_OP = 6'd1;
   localparam logic [5:0] CMD_READ    = 6'd17;

   localparam logic [1:0] CSR_IDLE_RETRIES  = 2'd0;
   localparam logic [1:0] CSR_READY_RETRIES = 2'd1;
   localparam logic [1:0] CSR_TOKEN_TIMEOUT = 2'd2;

   localparam logic [7:0] BYTE_FILL   = 8'hFF;
   localparam logic [7:0] BYTE_START  = 8'h40;
   localparam logic [7:0] BYTE_CRC0   = 8'h95;
   localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [7:0] R1_READY    = 8'h00;

   localparam logic [15:0] IDLE_RETRIES_RST  = 16'd100;
   localparam logic [15:0] READY_RETRIES_RST = 16'd32000;
   localparam logic [15:0] TOKEN_TIMEOUT_RST = 16'hFFFF;

   localparam logic [2:0] FRAME_LAST = 3'd7;

   function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] cmd,
                                             input logic [31:0] arg);
      logic [7:0] b;
      case (pos)
         3'd1:    b = BYTE_START | {2'b00, cmd};
         3'd2:    b = arg[31:24];
         3'd3:    b = arg[23:16];
         3'd4:    b = arg[15:8];
         3'd5:    b = arg[7:0];
         3'd6:    b = BYTE_CRC0;
         default: b = BYTE_FILL;
      endcase
      return b;
   endfunction

endpackage

@@ design/sd_spi_init_and_block_read_core.sv @@
// SD card SPI-mode host sequencer: init (CMD0/CMD1) and single-block read (CMD17).
// Depends on sdspi_pkg and assert_macros.svh.
//
// Usage:
//  - req channel: one request per SPI byte decision. tuser holds the request
//    kind (init, sector read, received byte); tdata holds sector address,
//    read length and the byte the card returned in the last exchange.
//  - rsp channel: exactly one response per request. It names the next byte to
//    shift out, chip select, an optional delivered sector byte with its index,
//    a done flag with status, and the card byte seen on this request.
//  - csr port: write enable, register index and 16-bit data; retry and timeout
//    registers are loaded when the next operation starts using them.
//  - The response is registered as the request is taken.
//  - Throughput: one request per cycle while each response is taken; the whole
//    decision is one pass through the state update logic between the sequencer
//    registers and the response register.
//  - Reset returns the sequencer to idle with no response pending and the csr
//    registers at their defaults; the response data register is not reset.
//  - When rsp_tready is low the response register holds and req_tready drops
//    until the pending response is taken.
`include "assert_macros.svh"

module sd_spi_init_and_block_read_core #(
   parameter int unsigned MAX_POLLS = sdspi_pkg::MAX_POLLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [22:0] sector_address, [32:23] read_length, [40:33] rx_byte, [47:41] zero
   input  logic [47:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] chip_select, [10] data_valid,
   // [18:11] data_byte, [27:19] data_index, [28] done_res, [31:29] status,
   // [39:32] card_reply
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned POLL_W = (MAX_POLLS > 1) ? $clog2(MAX_POLLS) : 1;
   localparam logic [POLL_W-1:0] POLL_LAST = POLL_W'(MAX_POLLS - 1);
   localparam logic [sdspi_pkg::CNT_W-1:0] BLOCK_CNT =
      sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE, PH_FRAME, PH_REPLY, PH_TOKEN, PH_DATA, PH_CRC, PH_BUSY
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [2:0]                    frame_pos_ff, frame_pos_in;
   logic [POLL_W-1:0]             poll_ff, poll_in;
   logic [15:0]                   retry_ff, retry_in;
   logic [15:0]                   timeout_ff, timeout_in;
   logic [sdspi_pkg::CNT_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [31:0]                   arg_ff, arg_in;
   logic [5:0]                    cmd_ff, cmd_in;
   logic [sdspi_pkg::CNT_W-1:0]   keep_ff, keep_in;
   logic [7:0]                    first_reply_ff, first_reply_in;
   logic [15:0]                   idle_retries_ff, ready_retries_ff, token_timeout_ff;
   logic                          rsp_valid_ff;
   logic [39:0]                   rsp_data_ff, rsp_data_in;

   logic [22:0]                   sector;
   logic [sdspi_pkg::CNT_W-1:0]   read_len;
   logic [7:0]                    rx;
   logic                          accept;
   logic                          send, fin, dv;
   logic [7:0]                    tx, db, reply;
   logic [sdspi_pkg::IDX_W-1:0]   di;
   logic [2:0]                    st;
   logic [sdspi_pkg::CNT_W-1:0]   byte_cnt_inc;

   assign sector       = req_tdata[22:0];
   assign read_len     = req_tdata[32:23];
   assign rx           = req_tdata[40:33];
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign byte_cnt_inc = byte_cnt_ff + sdspi_pkg::CNT_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      frame_pos_in   = frame_pos_ff;
      poll_in        = poll_ff;
      retry_in       = retry_ff;
      timeout_in     = timeout_ff;
      byte_cnt_in    = byte_cnt_ff;
      arg_in         = arg_ff;
      cmd_in         = cmd_ff;
      keep_in        = keep_ff;
      first_reply_in = first_reply_ff;
      send           = 1'b0;
      tx             = sdspi_pkg::BYTE_FILL;
      fin            = 1'b0;
      st             = sdspi_pkg::ST_OK;
      dv             = 1'b0;
      db             = 8'd0;
      di             = '0;
      reply          = 8'd0;
      case (req_tuser)
         sdspi_pkg::REQ_INIT: begin
            retry_in     = idle_retries_ff;
            cmd_in       = sdspi_pkg::CMD_GO_IDLE;
            arg_in       = 32'd0;
            frame_pos_in = 3'd0;
            phase_in     = PH_FRAME;
            send         = 1'b1;
         end
         sdspi_pkg::REQ_READ: begin
            keep_in      = read_len;
            cmd_in       = sdspi_pkg::CMD_READ;
            arg_in       = {sector, 9'd0};
            frame_pos_in = 3'd0;
            phase_in     = PH_FRAME;
            send         = 1'b1;
         end
         sdspi_pkg::REQ_BYTE: begin
            reply = rx;
            case (phase_ff)
               PH_FRAME: begin
                  if (frame_pos_ff < sdspi_pkg::FRAME_LAST) begin
                     frame_pos_in = frame_pos_ff + 3'd1;
                     tx = sdspi_pkg::frame_byte(frame_pos_ff + 3'd1, cmd_ff, arg_ff);
                  end else begin
                     phase_in = PH_REPLY;
                     poll_in  = '0;
                  end
                  send = 1'b1;
               end
               PH_REPLY: begin
                  if (rx == sdspi_pkg::BYTE_FILL && poll_ff < POLL_LAST) begin
                     poll_in = poll_ff + POLL_W'(1);
                     send    = 1'b1;
                  end else if (cmd_ff == sdspi_pkg::CMD_GO_IDLE) begin
                     if (rx == sdspi_pkg::R1_IDLE) begin
                        retry_in     = ready_retries_ff;
                        cmd_in       = sdspi_pkg::CMD_SEND_OP;
                        arg_in       = 32'd0;
                        frame_pos_in = 3'd0;
                        phase_in     = PH_FRAME;
                        send         = 1'b1;
                     end else if (retry_ff != 16'd0) begin
                        retry_in     = retry_ff - 16'd1;
                        cmd_in       = sdspi_pkg::CMD_GO_IDLE;
                        arg_in       = 32'd0;
                        frame_pos_in = 3'd0;
                        phase_in     = PH_FRAME;
                        send         = 1'b1;
                     end else begin
                        fin = 1'b1;
                        st  = (rx == sdspi_pkg::BYTE_FILL) ? sdspi_pkg::ST_NO_REPLY
                                                           : sdspi_pkg::ST_IDLE_ERR;
                     end
                  end else if (cmd_ff == sdspi_pkg::CMD_SEND_OP) begin
                     if (rx == sdspi_pkg::R1_READY) begin
                        fin = 1'b1;
                     end else if (rx == sdspi_pkg::R1_IDLE && retry_ff != 16'd0) begin
                        retry_in     = retry_ff - 16'd1;
                        cmd_in       = sdspi_pkg::CMD_SEND_OP;
                        arg_in       = 32'd0;
                        frame_pos_in = 3'd0;
                        phase_in     = PH_FRAME;
                        send         = 1'b1;
                     end else begin
                        fin = 1'b1;
                        st  = sdspi_pkg::ST_READY_FAIL;
                     end
                  end else begin
                     first_reply_in = rx;
                     phase_in       = PH_TOKEN;
                     poll_in        = '0;
                     timeout_in     = token_timeout_ff;
                     send           = 1'b1;
                  end
               end
               PH_TOKEN: begin
                  if (rx == sdspi_pkg::BYTE_FILL) begin
                     if (poll_ff < POLL_LAST) begin
                        poll_in = poll_ff + POLL_W'(1);
                        send    = 1'b1;
                     end else if (timeout_ff != 16'd0) begin
                        timeout_in = timeout_ff - 16'd1;
                        poll_in    = '0;
                        send       = 1'b1;
                     end else begin
                        fin = 1'b1;
                        st  = sdspi_pkg::ST_READ_ERR;
                     end
                  end else if (first_reply_ff != sdspi_pkg::R1_READY ||
                               rx != sdspi_pkg::BYTE_TOKEN) begin
                     fin = 1'b1;
                     st  = sdspi_pkg::ST_READ_ERR;
                  end else begin
                     phase_in    = PH_DATA;
                     byte_cnt_in = '0;
                     send        = 1'b1;
                  end
               end
               PH_DATA: begin
                  if (byte_cnt_ff < keep_ff) begin
                     dv = 1'b1;
                     db = rx;
                     di = byte_cnt_ff[sdspi_pkg::IDX_W-1:0];
                  end
                  byte_cnt_in = byte_cnt_inc;
                  if (byte_cnt_inc >= BLOCK_CNT) begin
                     phase_in = PH_CRC;
                  end
                  send = 1'b1;
               end
               PH_CRC: begin
                  phase_in = PH_BUSY;
                  send     = 1'b1;
               end
               PH_BUSY: begin
                  if (rx == sdspi_pkg::BYTE_FILL) begin
                     fin = 1'b1;
                  end else begin
                     send = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      if (fin) begin
         phase_in = PH_IDLE;
         send     = 1'b0;
      end
      rsp_data_in = {reply, st, fin, di, db, dv, (phase_in != PH_IDLE),
                     (send ? tx : 8'd0), send};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         frame_pos_ff     <= 3'd0;
         poll_ff          <= '0;
         retry_ff         <= 16'd0;
         timeout_ff       <= 16'd0;
         byte_cnt_ff      <= '0;
         arg_ff           <= 32'd0;
         cmd_ff           <= 6'd0;
         keep_ff          <= '0;
         first_reply_ff   <= sdspi_pkg::BYTE_FILL;
         idle_retries_ff  <= sdspi_pkg::IDLE_RETRIES_RST;
         ready_retries_ff <= sdspi_pkg::READY_RETRIES_RST;
         token_timeout_ff <= sdspi_pkg::TOKEN_TIMEOUT_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               sdspi_pkg::CSR_IDLE_RETRIES:  idle_retries_ff  <= csr_wdata;
               sdspi_pkg::CSR_READY_RETRIES: ready_retries_ff <= csr_wdata;
               sdspi_pkg::CSR_TOKEN_TIMEOUT: token_timeout_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff       <= phase_in;
            frame_pos_ff   <= frame_pos_in;
            poll_ff        <= poll_in;
            retry_ff       <= retry_in;
            timeout_ff     <= timeout_in;
            byte_cnt_ff    <= byte_cnt_in;
            arg_ff         <= arg_in;
            cmd_ff         <= cmd_in;
            keep_ff        <= keep_in;
            first_reply_ff <= first_reply_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_NEXT(a_req_gives_rsp, clock, reset, accept, rsp_tvalid)
   `ASSERT_IMPLY(a_done_deselects, clock, reset, rsp_tvalid && rsp_tdata[28],
                 !rsp_tdata[0] && !rsp_tdata[9])
   `ASSERT_IMPLY(a_data_in_block, clock, reset, phase_ff == PH_DATA,
                 byte_cnt_ff < BLOCK_CNT)

endmodule
